>>> hdl/sequential_joint_slew_sequencer_assert.svh
// ----------------------------------------------------------------------------
// Sequential joint slew sequencer assertion macros
// Concurrent assertion shorthands clocked on aclk, off while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef SEQUENTIAL_JOINT_SLEW_SEQUENCER_ASSERT_SVH
`define SEQUENTIAL_JOINT_SLEW_SEQUENCER_ASSERT_SVH

// same-cycle implication
`define SJSS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SJSS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/sjss_pkg.sv
// ----------------------------------------------------------------------------
// Sequential joint slew sequencer package
// Widths, field positions and codes shared by the sequencer and its checker.
// ----------------------------------------------------------------------------
package sjss_pkg;

    localparam int NUM_JOINTS    = 4;
    localparam int POS_WIDTH     = 16;
    localparam int JOINT_W       = 2;
    localparam int STEP_WIDTH    = 15;
    localparam int DELAY_WIDTH   = 16;
    localparam int CFG_IDX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH = 16;

    localparam int S_TDATA_WIDTH = NUM_JOINTS * POS_WIDTH;
    localparam int S_TUSER_WIDTH = 2;
    localparam int TUSER_CMD     = 0;
    localparam int TUSER_VALID   = 1;

    localparam int ACTIVE_LSB    = NUM_JOINTS * POS_WIDTH;
    localparam int STARTED_BIT   = ACTIVE_LSB + JOINT_W;
    localparam int M_PAYLOAD_W   = STARTED_BIT + 1;
    localparam int M_TDATA_WIDTH = ((M_PAYLOAD_W + 7) / 8) * 8;

    typedef enum logic {
        CMD_TICK   = 1'b0,
        CMD_TARGET = 1'b1
    } cmd_t;

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        REG_INIT_POS_0  = 3'd0,
        REG_INIT_POS_1  = 3'd1,
        REG_INIT_POS_2  = 3'd2,
        REG_INIT_POS_3  = 3'd3,
        REG_STEP_SIZE   = 3'd4,
        REG_TOLERANCE   = 3'd5,
        REG_DELAY_TICKS = 3'd6
    } reg_index_t;

    localparam logic [STEP_WIDTH-1:0]  STEP_SIZE_RESET   = 15'd49;
    localparam logic [STEP_WIDTH-1:0]  TOLERANCE_RESET   = 15'd41;
    localparam logic [DELAY_WIDTH-1:0] DELAY_TICKS_RESET = 16'd250;

    typedef logic signed [POS_WIDTH-1:0] pos_t;

endpackage

>>> hdl/sequential_joint_slew_sequencer.sv
// ----------------------------------------------------------------------------
// Sequential joint slew sequencer
// Moves four joints one at a time toward stored targets at a bounded step.
// ----------------------------------------------------------------------------
// Target requests (tuser cmd set) return nothing; with targets_valid set they
// replace the targets, and the first one loads the pose from the initial-pose
// registers and arms the start delay. Tick requests return one result each: all
// joint positions, the active joint and the started flag. Requests are taken
// while the output register is free or draining, each result showing on the
// master side in the next cycle; the single output register sets the
// one-request-per-cycle rate while m_tready is high. The configuration channel
// is always ready; it must be written only while idle, unchecked by the block.
module sequential_joint_slew_sequencer (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // target_0, target_1, target_2, target_3
    input  logic [sjss_pkg::S_TDATA_WIDTH-1:0]     s_tdata,
    // cmd, targets_valid
    input  logic [sjss_pkg::S_TUSER_WIDTH-1:0]     s_tuser,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // pos_0, pos_1, pos_2, pos_3, active_joint, motion_started, zero pad
    output logic [sjss_pkg::M_TDATA_WIDTH-1:0]     m_tdata,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [sjss_pkg::CFG_IDX_WIDTH-1:0]     cfg_index,
    input  logic [sjss_pkg::CFG_DATA_WIDTH-1:0]    cfg_data
);
    import sjss_pkg::*;

    pos_t                   init_pos_reg [NUM_JOINTS];
    logic [STEP_WIDTH-1:0]  step_size_reg;
    logic [STEP_WIDTH-1:0]  tolerance_reg;
    logic [DELAY_WIDTH-1:0] delay_ticks_reg;

    pos_t                   cur_pos_reg  [NUM_JOINTS];
    pos_t                   cur_pos_next [NUM_JOINTS];
    pos_t                   tgt_pos_reg  [NUM_JOINTS];
    pos_t                   tgt_pos_next [NUM_JOINTS];
    logic                   have_target_reg, have_target_next;
    logic                   started_reg, started_next;
    logic [JOINT_W-1:0]     active_reg, active_next;
    logic [DELAY_WIDTH-1:0] delay_count_reg, delay_count_next;

    logic                   m_tvalid_reg;
    logic [M_TDATA_WIDTH-1:0] m_data_reg, m_data_next;

    logic                   accept;
    logic                   is_tick;
    pos_t                   sel_cur;
    pos_t                   sel_tgt;
    logic signed [POS_WIDTH:0] err;
    logic [POS_WIDTH:0]     err_abs;
    logic signed [POS_WIDTH:0] step_pos;
    logic signed [POS_WIDTH:0] step_neg;
    pos_t                   slewed;
    reg_index_t             cfg_reg_idx;

    assign s_tready  = !m_tvalid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign is_tick   = (s_tuser[TUSER_CMD] == CMD_TICK);
    assign cfg_ready = 1'b1;
    assign cfg_reg_idx = reg_index_t'(cfg_index);

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < NUM_JOINTS; j++) begin
                init_pos_reg[j] <= '0;
            end
            step_size_reg   <= STEP_SIZE_RESET;
            tolerance_reg   <= TOLERANCE_RESET;
            delay_ticks_reg <= DELAY_TICKS_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_reg_idx) inside
                REG_INIT_POS_0, REG_INIT_POS_1, REG_INIT_POS_2, REG_INIT_POS_3: begin
                    init_pos_reg[cfg_index[JOINT_W-1:0]] <= pos_t'(cfg_data[POS_WIDTH-1:0]);
                end
                REG_STEP_SIZE: begin
                    step_size_reg <= cfg_data[STEP_WIDTH-1:0];
                end
                REG_TOLERANCE: begin
                    tolerance_reg <= cfg_data[STEP_WIDTH-1:0];
                end
                REG_DELAY_TICKS: begin
                    delay_ticks_reg <= cfg_data[DELAY_WIDTH-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // slew arithmetic on the active joint
    always_comb begin
        sel_cur  = cur_pos_reg[active_reg];
        sel_tgt  = tgt_pos_reg[active_reg];
        err      = {sel_tgt[POS_WIDTH-1], sel_tgt} - {sel_cur[POS_WIDTH-1], sel_cur};
        err_abs  = err[POS_WIDTH] ? (POS_WIDTH+1)'(-err) : (POS_WIDTH+1)'(err);
        step_pos = {sel_cur[POS_WIDTH-1], sel_cur} + {2'b00, step_size_reg};
        step_neg = {sel_cur[POS_WIDTH-1], sel_cur} - {2'b00, step_size_reg};
        if (err_abs <= {2'b00, step_size_reg}) begin
            slewed = sel_tgt;
        end else if (err[POS_WIDTH]) begin
            slewed = step_neg[POS_WIDTH-1:0];
        end else begin
            slewed = step_pos[POS_WIDTH-1:0];
        end
    end

    // state update
    always_comb begin
        cur_pos_next     = cur_pos_reg;
        tgt_pos_next     = tgt_pos_reg;
        have_target_next = have_target_reg;
        started_next     = started_reg;
        active_next      = active_reg;
        delay_count_next = delay_count_reg;
        if (accept) begin
            if (!is_tick) begin
                if (s_tuser[TUSER_VALID]) begin
                    for (int j = 0; j < NUM_JOINTS; j++) begin
                        tgt_pos_next[j] = pos_t'(s_tdata[j*POS_WIDTH +: POS_WIDTH]);
                    end
                    if (!have_target_reg) begin
                        have_target_next = 1'b1;
                        cur_pos_next     = init_pos_reg;
                        delay_count_next = '0;
                        started_next     = 1'b0;
                        active_next      = '0;
                    end
                end
            end else if (have_target_reg) begin
                if (!started_reg) begin
                    if (delay_count_reg < delay_ticks_reg) begin
                        delay_count_next = delay_count_reg + 1'b1;
                    end else begin
                        started_next = 1'b1;
                    end
                end
                if (started_next) begin
                    if (err_abs <= {2'b00, tolerance_reg}) begin
                        if (active_reg == JOINT_W'(NUM_JOINTS - 1)) begin
                            active_next = '0;
                        end else begin
                            active_next = active_reg + 1'b1;
                        end
                    end else begin
                        cur_pos_next[active_reg] = slewed;
                    end
                end
            end
        end
    end

    // result packing
    always_comb begin
        m_data_next = '0;
        for (int j = 0; j < NUM_JOINTS; j++) begin
            m_data_next[j*POS_WIDTH +: POS_WIDTH] =
                have_target_next ? cur_pos_next[j] : init_pos_reg[j];
        end
        m_data_next[ACTIVE_LSB +: JOINT_W] = active_next;
        m_data_next[STARTED_BIT]           = started_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < NUM_JOINTS; j++) begin
                cur_pos_reg[j] <= '0;
                tgt_pos_reg[j] <= '0;
            end
            have_target_reg <= 1'b0;
            started_reg     <= 1'b0;
            active_reg      <= '0;
            delay_count_reg <= '0;
        end else begin
            cur_pos_reg     <= cur_pos_next;
            tgt_pos_reg     <= tgt_pos_next;
            have_target_reg <= have_target_next;
            started_reg     <= started_next;
            active_reg      <= active_next;
            delay_count_reg <= delay_count_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (accept && is_tick) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && is_tick) begin
            m_data_reg <= m_data_next;
        end
    end

endmodule

>>> hdl/sjss_checker.sv
// ----------------------------------------------------------------------------
// Sequential joint slew sequencer checker
// Port-level checks on results of the sequencer, bound into every sequencer instance.
// ----------------------------------------------------------------------------
`include "sequential_joint_slew_sequencer_assert.svh"

module sjss_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_tvalid,
    input logic                               s_tready,
    input logic [sjss_pkg::S_TUSER_WIDTH-1:0] s_tuser,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [sjss_pkg::M_TDATA_WIDTH-1:0] m_tdata
);
    import sjss_pkg::*;

    logic               s_req;
    logic               tick_req;
    logic               target_req;
    logic               m_stall;
    logic               m_started;
    logic [JOINT_W-1:0] m_joint;

    assign s_req      = s_tvalid && s_tready;
    assign tick_req   = aresetn && s_req && (s_tuser[TUSER_CMD] == CMD_TICK);
    assign target_req = s_req && (s_tuser[TUSER_CMD] == CMD_TARGET);
    assign m_stall    = m_tvalid && !m_tready;
    assign m_started  = m_tdata[STARTED_BIT];
    assign m_joint    = m_tdata[ACTIVE_LSB +: JOINT_W];

    `SJSS_ASSERT_NEXT(a_out_hold, m_stall, m_tvalid && $stable(m_tdata), "stalled result changed")
    `SJSS_ASSERT_NOW(a_from_tick, m_tvalid && !$past(m_tvalid), $past(tick_req), "stray result")
    `SJSS_ASSERT_NEXT(a_target_silent, target_req && !m_stall, !m_tvalid, "result after target")
    `SJSS_ASSERT_NOW(a_idle_joint_zero, m_tvalid && !m_started, m_joint == '0, "early hand-over")

endmodule

bind sequential_joint_slew_sequencer sjss_checker u_sjss_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
